// ===== rtl/itfr_pkg.sv =====
// Shared types and constants for the ISO-TP frame reassembler.
// No dependencies; every other file of the block imports this package.
package itfr_pkg;

  localparam int MAX_MSG_BYTES_DEF = 4095;
  localparam int QUEUE_DEPTH       = 2;

  // Frame type codes (high nibble of the protocol control byte)
  localparam logic [3:0] PCI_SINGLE      = 4'h0;
  localparam logic [3:0] PCI_FIRST       = 4'h1;
  localparam logic [3:0] PCI_CONSECUTIVE = 4'h2;

  localparam logic [3:0] DLC_MAX        = 4'd8;
  localparam logic [3:0] SF_MAX_LEN     = 4'd7;
  localparam logic [2:0] CF_MAX_BYTES   = 3'd7;
  localparam logic [2:0] FF_BYTES       = 3'd6;
  localparam logic [11:0] FF_MIN_TOTAL  = 12'd7;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_RECEIVING = 2'd1,
    PH_COMPLETE  = 2'd2,
    PH_ERROR     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_COMPLETE = 2'd1,
    EV_FLOW     = 2'd2,
    EV_ERROR    = 2'd3
  } event_t;

  typedef struct packed {
    logic [1:0]  bus_number;
    logic [28:0] can_id;
    logic        is_extended;
    logic [3:0]  dlc;
    logic [7:0]  data_byte_0;
    logic [7:0]  data_byte_1;
    logic [7:0]  data_byte_2;
    logic [7:0]  data_byte_3;
    logic [7:0]  data_byte_4;
    logic [7:0]  data_byte_5;
    logic [7:0]  data_byte_6;
    logic [7:0]  data_byte_7;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic        byte_valid;
    logic [7:0]  payload_byte;
    logic [11:0] byte_offset;
    logic        last_result;
    logic [11:0] message_length;
  } out_word_t;

  // One classified frame, handed from front to back
  typedef struct packed {
    logic [6:0][7:0] bytes;
    logic [2:0]      count;
    logic [11:0]     base_offset;
    event_t          event_code;
    logic [11:0]     message_length;
  } job_t;

endpackage

// ===== rtl/itfr_front.sv =====
// Front end: accepts CAN frames, checks them against the transfer state and
// builds one job per frame. Depends on itfr_pkg.
module itfr_front import itfr_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_word_t frame,
  input  logic     cfg_we,
  input  logic [7:0] cfg_wdata,
  output job_t     job
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  src_bus_r, src_bus_nxt;
  logic [28:0] src_id_r, src_id_nxt;
  logic        src_ext_r, src_ext_nxt;
  logic [11:0] total_r, total_nxt;
  logic [11:0] rcvd_r, rcvd_nxt;
  logic [3:0]  seq_r, seq_nxt;
  logic [7:0]  fib_r, fib_nxt;
  logic [7:0]  blk_len_r, blk_len_nxt;

  logic [7:0][7:0] d;
  logic [3:0]  pci_type, pci_low;
  logic        foreign;
  logic [11:0] ff_total;
  logic [11:0] remaining;
  logic [2:0]  cf_n;
  logic [11:0] rcvd_new;
  logic [7:0]  fib_new;

  assign d = {frame.data_byte_7, frame.data_byte_6, frame.data_byte_5, frame.data_byte_4,
              frame.data_byte_3, frame.data_byte_2, frame.data_byte_1, frame.data_byte_0};
  assign pci_type = d[0][7:4];
  assign pci_low  = d[0][3:0];
  assign foreign  = (phase_r == PH_RECEIVING) &&
                    (frame.bus_number != src_bus_r || frame.can_id != src_id_r ||
                     frame.is_extended != src_ext_r);
  assign ff_total  = {pci_low, d[1]};
  assign remaining = (total_r > rcvd_r) ? (total_r - rcvd_r) : 12'd0;
  assign cf_n      = (remaining > {9'd0, CF_MAX_BYTES}) ? CF_MAX_BYTES : remaining[2:0];
  assign rcvd_new  = rcvd_r + {9'd0, cf_n};
  assign fib_new   = (blk_len_r != 8'd0) ? (fib_r + 8'd1) : fib_r;

  always_comb begin
    phase_nxt      = phase_r;
    src_bus_nxt    = src_bus_r;
    src_id_nxt     = src_id_r;
    src_ext_nxt    = src_ext_r;
    total_nxt      = total_r;
    rcvd_nxt       = rcvd_r;
    seq_nxt        = seq_r;
    fib_nxt        = fib_r;
    blk_len_nxt    = blk_len_r;
    job.bytes       = d[7:1];
    job.count       = 3'd0;
    job.base_offset = 12'd0;
    job.event_code  = EV_NONE;

    if (accept && !foreign) begin
      if (frame.dlc == 4'd0 || frame.dlc > DLC_MAX) begin
        phase_nxt      = PH_ERROR;
        job.event_code = EV_ERROR;
      end else begin
        unique case (pci_type)
          PCI_SINGLE: begin
            if (pci_low == 4'd0 || pci_low > SF_MAX_LEN ||
                ({1'b0, pci_low} + 5'd1) > {1'b0, frame.dlc}) begin
              phase_nxt      = PH_ERROR;
              job.event_code = EV_ERROR;
            end else begin
              src_bus_nxt    = frame.bus_number;
              src_id_nxt     = frame.can_id;
              src_ext_nxt    = frame.is_extended;
              total_nxt      = {8'd0, pci_low};
              rcvd_nxt       = {8'd0, pci_low};
              phase_nxt      = PH_COMPLETE;
              job.count      = pci_low[2:0];
              job.event_code = EV_COMPLETE;
            end
          end
          PCI_FIRST: begin
            if (frame.dlc < DLC_MAX || ff_total <= FF_MIN_TOTAL ||
                ff_total > 12'(MAX_MESSAGE_BYTES)) begin
              phase_nxt      = PH_ERROR;
              job.event_code = EV_ERROR;
            end else begin
              src_bus_nxt    = frame.bus_number;
              src_id_nxt     = frame.can_id;
              src_ext_nxt    = frame.is_extended;
              total_nxt      = ff_total;
              rcvd_nxt       = {9'd0, FF_BYTES};
              seq_nxt        = 4'd1;
              fib_nxt        = 8'd0;
              phase_nxt      = PH_RECEIVING;
              job.bytes      = {8'h00, d[7:2]};
              job.count      = FF_BYTES;
              job.event_code = EV_FLOW;
            end
          end
          PCI_CONSECUTIVE: begin
            if (phase_r != PH_RECEIVING || pci_low != seq_r) begin
              phase_nxt      = PH_ERROR;
              job.event_code = EV_ERROR;
            end else begin
              seq_nxt = seq_r + 4'd1;
              if (({1'b0, cf_n} + 4'd1) > frame.dlc) begin
                phase_nxt      = PH_ERROR;
                job.event_code = EV_ERROR;
              end else begin
                job.count       = cf_n;
                job.base_offset = rcvd_r;
                rcvd_nxt        = rcvd_new;
                fib_nxt         = fib_new;
                if (rcvd_new >= total_r) begin
                  phase_nxt      = PH_COMPLETE;
                  job.event_code = EV_COMPLETE;
                end else if (blk_len_r != 8'd0 && fib_new >= blk_len_r) begin
                  fib_nxt        = 8'd0;
                  job.event_code = EV_FLOW;
                end
              end
            end
          end
          default: begin
            // flow control and reserved types: drop
          end
        endcase
      end
    end

    if (cfg_we) begin
      blk_len_nxt = cfg_wdata;
      fib_nxt     = 8'd0;
    end

    job.message_length = total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      src_bus_r    <= 2'd0;
      src_id_r     <= 29'd0;
      src_ext_r    <= 1'b0;
      total_r      <= 12'd0;
      rcvd_r       <= 12'd0;
      seq_r        <= 4'd0;
      fib_r        <= 8'd0;
      blk_len_r    <= 8'd0;
    end else begin
      phase_r      <= phase_nxt;
      src_bus_r    <= src_bus_nxt;
      src_id_r     <= src_id_nxt;
      src_ext_r    <= src_ext_nxt;
      total_r      <= total_nxt;
      rcvd_r       <= rcvd_nxt;
      seq_r        <= seq_nxt;
      fib_r        <= fib_nxt;
      blk_len_r    <= blk_len_nxt;
    end
  end

endmodule

// ===== rtl/itfr_queue.sv =====
// Short job queue between front and back of the reassembler.
// Depends on itfr_pkg for the job type and depth.
module itfr_queue import itfr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic head_valid,
  output logic full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

  job_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head_job   = mem[rd_ptr_r];
  assign head_valid = (cnt_r != '0);
  assign full       = (cnt_r == DEPTH_C);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");

endmodule

// ===== rtl/itfr_back.sv =====
// Back end: expands each job into its result words, one per cycle while the
// output is not stalled, into the output register. Depends on itfr_pkg.
module itfr_back import itfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head_job,
  input  logic      head_valid,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic [2:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_r, out_nxt;
  logic       load;
  logic       last;
  logic       has_bytes;

  assign has_bytes = (head_job.count != 3'd0);
  assign last      = !has_bytes || (idx_r == head_job.count - 3'd1);
  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign pop       = load && last;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (load) begin
      out_valid_nxt          = 1'b1;
      out_nxt.event_res      = last ? head_job.event_code : EV_NONE;
      out_nxt.byte_valid     = has_bytes;
      out_nxt.payload_byte   = has_bytes ? head_job.bytes[idx_r] : 8'd0;
      out_nxt.byte_offset    = has_bytes ? (head_job.base_offset + {9'd0, idx_r}) : 12'd0;
      out_nxt.last_result    = last;
      out_nxt.message_length = head_job.message_length;
      idx_nxt                = last ? 3'd0 : idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r && out_r.last_result)
    else $error("job retired without a last word");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.byte_valid) |-> out_r.last_result)
    else $error("byteless word that is not last");

endmodule

// ===== rtl/isotp_frame_reassembler.sv =====
// ISO-TP receive reassembler: top level joining front, job queue and back.
// Depends on itfr_pkg, itfr_front, itfr_queue and itfr_back.
//
// Takes one CAN frame per input word and returns its payload bytes with
// their offsets in the reassembled message, one output word per byte, or a
// single byteless word when the frame carries none (error, ignored frame,
// foreign source). The last word of a frame carries the event: none,
// complete, need flow control or error. The front checks and classifies a
// frame in the cycle it is accepted and may accept one every cycle while the
// queue has room; the back emits one output word per cycle while out_stall
// is low, up to 7 words for a frame, and that emitter sets the sustained
// rate. A two-entry job queue parts front from back; in_stall rises only
// when it is full. With the back idle, an accepted frame is written into the
// job queue and its first output word then into the back's output register.
// cfg_we writes the block length (0 = no flow-control limit) and clears the
// block frame count; write it only while no frame is in flight.
module isotp_frame_reassembler import itfr_pkg::*; #(
  parameter int MAX_MESSAGE_BYTES = MAX_MSG_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_data,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic accept;
  job_t new_job;
  job_t head_job;
  logic head_valid;
  logic q_full;
  logic q_pop;

  // Hold the input while the queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  itfr_front #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .frame    (in_data),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .job      (new_job)
  );

  itfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_job  (new_job),
    .pop       (q_pop),
    .head_job  (head_job),
    .head_valid(head_valid),
    .full      (q_full)
  );

  itfr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .head_valid(head_valid),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for isotp_frame_reassembler: streams CAN frame words into the block and
// checks every output word against a cycle-free model of the ISO-TP receive rules.
// Depends on itfr_pkg and the RTL of the reassembler.
module tb;
  import itfr_pkg::*;

  localparam int MSG_LIMIT = MAX_MSG_BYTES_DEF;

  typedef struct packed {
    logic [1:0]  bus;
    logic [28:0] id;
    logic        ext;
  } src_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  isotp_frame_reassembler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Frames waiting for the driver, and output words the model says must come next.
  in_word_t  frames_to_send[$];
  out_word_t awaited_words[$];
  int unsigned mismatches = 0;

  // ---------------------------------------------------------------------------
  // Transfer model: its own copy of the receive state and of the block limit.
  // ---------------------------------------------------------------------------
  phase_t      rx_phase;
  logic [1:0]  rx_bus;
  logic [28:0] rx_id;
  logic        rx_ext;
  logic [11:0] rx_total;
  logic [11:0] rx_count;
  logic [3:0]  rx_seq;
  logic [7:0]  blk_frames;
  logic [7:0]  blk_limit;

  function automatic void clear_transfer_state();
    rx_phase   = PH_IDLE;
    rx_bus     = '0;
    rx_id      = '0;
    rx_ext     = 1'b0;
    rx_total   = '0;
    rx_count   = '0;
    rx_seq     = '0;
    blk_frames = '0;
    blk_limit  = '0;
  endfunction

  // Queue one word per payload byte, or one byteless word; the last carries the event.
  function automatic void queue_words(logic [6:0][7:0] data, logic [11:0] base, int n,
                                      event_t ev);
    out_word_t w;
    int k;
    int cnt;
    cnt = (n > 0) ? n : 1;
    for (k = 0; k < cnt; k++) begin
      w.event_res      = (k == cnt - 1) ? ev : EV_NONE;
      w.byte_valid     = (n > 0);
      w.payload_byte   = (n > 0) ? data[k] : 8'h00;
      w.byte_offset    = (n > 0) ? base + 12'(k) : 12'h000;
      w.last_result    = (k == cnt - 1);
      w.message_length = rx_total;
      awaited_words.push_back(w);
    end
  endfunction

  function automatic void reassemble_frame(in_word_t f);
    logic [6:0][7:0] data;
    logic [6:0][7:0] ff_data;
    logic [3:0]      info;
    logic [11:0]     total;
    logic [11:0]     base;
    int              remain;
    int              n;
    event_t          ev;
    data    = {f.data_byte_7, f.data_byte_6, f.data_byte_5, f.data_byte_4,
               f.data_byte_3, f.data_byte_2, f.data_byte_1};
    ff_data = {8'h00, f.data_byte_7, f.data_byte_6, f.data_byte_5,
               f.data_byte_4, f.data_byte_3, f.data_byte_2};
    info    = f.data_byte_0[3:0];

    // Drop frames from any other source while a transfer is open.
    if (rx_phase == PH_RECEIVING && (f.bus_number != rx_bus || f.can_id != rx_id ||
                                     f.is_extended != rx_ext)) begin
      queue_words(data, '0, 0, EV_NONE);
      return;
    end
    if (f.dlc == 4'd0 || f.dlc > DLC_MAX) begin
      rx_phase = PH_ERROR;
      queue_words(data, '0, 0, EV_ERROR);
      return;
    end

    case (f.data_byte_0[7:4])
      PCI_SINGLE: begin
        if (info == 4'd0 || info > SF_MAX_LEN || int'(info) + 1 > int'(f.dlc)) begin
          rx_phase = PH_ERROR;
          queue_words(data, '0, 0, EV_ERROR);
        end else begin
          rx_bus   = f.bus_number;
          rx_id    = f.can_id;
          rx_ext   = f.is_extended;
          rx_total = 12'(info);
          rx_count = 12'(info);
          rx_phase = PH_COMPLETE;
          queue_words(data, '0, int'(info), EV_COMPLETE);
        end
      end
      PCI_FIRST: begin
        total = {info, f.data_byte_1};
        if (f.dlc < DLC_MAX || total <= FF_MIN_TOTAL || int'(total) > MSG_LIMIT) begin
          rx_phase = PH_ERROR;
          queue_words(data, '0, 0, EV_ERROR);
        end else begin
          rx_bus     = f.bus_number;
          rx_id      = f.can_id;
          rx_ext     = f.is_extended;
          rx_total   = total;
          rx_count   = 12'(FF_BYTES);
          rx_seq     = 4'd1;
          blk_frames = '0;
          rx_phase   = PH_RECEIVING;
          queue_words(ff_data, '0, int'(FF_BYTES), EV_FLOW);
        end
      end
      PCI_CONSECUTIVE: begin
        if (rx_phase != PH_RECEIVING || info != rx_seq) begin
          rx_phase = PH_ERROR;
          queue_words(data, '0, 0, EV_ERROR);
          return;
        end
        // The sequence advances before the length check, so a short frame still counts.
        rx_seq = rx_seq + 4'd1;
        remain = (rx_total > rx_count) ? int'(rx_total - rx_count) : 0;
        n      = (remain > int'(CF_MAX_BYTES)) ? int'(CF_MAX_BYTES) : remain;
        if (n + 1 > int'(f.dlc)) begin
          rx_phase = PH_ERROR;
          queue_words(data, '0, 0, EV_ERROR);
          return;
        end
        base     = rx_count;
        rx_count = rx_count + 12'(n);
        if (blk_limit != 8'd0) blk_frames = blk_frames + 8'd1;
        ev = EV_NONE;
        if (rx_count >= rx_total) begin
          rx_phase = PH_COMPLETE;
          ev       = EV_COMPLETE;
        end else if (blk_limit != 8'd0 && blk_frames >= blk_limit) begin
          blk_frames = '0;
          ev         = EV_FLOW;
        end
        queue_words(data, base, n, ev);
      end
      default: queue_words(data, '0, 0, EV_NONE);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Frame builders
  // ---------------------------------------------------------------------------
  src_t main_src;

  function automatic src_t random_src();
    src_t s;
    s.bus = 2'($urandom);
    s.id  = 29'($urandom);
    s.ext = 1'($urandom);
    return s;
  endfunction

  // Differ from s in exactly one of bus, id or id type.
  function automatic src_t foreign_of(src_t s);
    src_t o;
    o = s;
    case ($urandom_range(0, 2))
      0:       o.bus = s.bus ^ 2'($urandom_range(1, 3));
      1:       o.id  = s.id ^ (29'($urandom) | (29'd1 << $urandom_range(0, 28)));
      default: o.ext = ~s.ext;
    endcase
    return o;
  endfunction

  function automatic in_word_t build_frame(src_t s, logic [3:0] dlc, logic [7:0] pci);
    in_word_t f;
    f.bus_number  = s.bus;
    f.can_id      = s.id;
    f.is_extended = s.ext;
    f.dlc         = dlc;
    f.data_byte_0 = pci;
    {f.data_byte_1, f.data_byte_2, f.data_byte_3, f.data_byte_4} = $urandom;
    {f.data_byte_5, f.data_byte_6, f.data_byte_7} = 24'($urandom);
    return f;
  endfunction

  function automatic void add_frame(src_t s, logic [3:0] dlc, logic [7:0] pci);
    frames_to_send.push_back(build_frame(s, dlc, pci));
  endfunction

  function automatic void add_first(src_t s, logic [11:0] total, logic [3:0] dlc);
    in_word_t f;
    f = build_frame(s, dlc, {PCI_FIRST, total[11:8]});
    f.data_byte_1 = total[7:0];
    frames_to_send.push_back(f);
  endfunction

  // Foreign noise never opens a transfer, so the main source keeps the block.
  function automatic void add_foreign_noise(src_t s);
    in_word_t f;
    f = build_frame(foreign_of(s), 4'($urandom), 8'($urandom));
    if (f.data_byte_0[7:4] == PCI_FIRST) f.data_byte_0[7:4] = 4'h3;
    frames_to_send.push_back(f);
  endfunction

  // First frame plus consecutive frames; unless clean, interleave foreign frames and
  // now and then break the transfer by a wrong sequence, a short dlc or by abandoning it.
  function automatic void add_transfer(src_t s, int total, bit clean);
    int         left;
    int         n;
    logic [3:0] seq;
    add_first(s, 12'(total), 4'd8);
    left = total - int'(FF_BYTES);
    seq  = 4'd1;
    while (left > 0) begin
      n = (left > 7) ? 7 : left;
      if (!clean && $urandom_range(0, 9) == 0) add_foreign_noise(s);
      if (!clean && $urandom_range(0, 29) == 0) begin
        case ($urandom_range(0, 2))
          0: add_frame(s, 4'd8, {PCI_CONSECUTIVE, 4'(seq + 4'($urandom_range(1, 14)))});
          1: add_frame(s, 4'($urandom_range(1, n)), {PCI_CONSECUTIVE, seq});
          default: ;
        endcase
        return;
      end
      add_frame(s, 4'($urandom_range(n + 1, 8)), {PCI_CONSECUTIVE, seq});
      seq  = seq + 4'd1;
      left = left - n;
    end
  endfunction

  function automatic void load_directed();
    src_t     b;
    src_t     x;
    in_word_t f;
    b = foreign_of(main_src);
    add_frame(main_src, 4'd2, {PCI_SINGLE, 4'd1});
    add_frame(main_src, 4'd8, {PCI_SINGLE, 4'd7});
    add_frame(main_src, 4'd8, {PCI_SINGLE, 4'd0});     // zero length
    add_frame(main_src, 4'd8, {PCI_SINGLE, 4'd8});     // length above seven
    add_frame(main_src, 4'd5, {PCI_SINGLE, 4'd5});     // length past the dlc
    add_frame(main_src, 4'd0, {PCI_SINGLE, 4'd1});     // bad dlc
    add_frame(main_src, 4'd9, {PCI_SINGLE, 4'd1});
    add_frame(main_src, 4'd15, {PCI_SINGLE, 4'd1});
    add_first(main_src, 12'd20, 4'd7);                 // short first frame
    add_first(main_src, 12'd7, 4'd8);                  // total too small
    add_frame(main_src, 4'd8, {PCI_CONSECUTIVE, 4'd1}); // stray, nothing open
    add_first(main_src, 12'd8, 4'd8);
    add_frame(main_src, 4'd3, {PCI_CONSECUTIVE, 4'd1}); // two bytes, completes
    add_frame(main_src, 4'd8, {PCI_CONSECUTIVE, 4'd2}); // stray after completion
    // Open transfer: frames differing in bus, id or id type alone are ignored.
    add_first(main_src, 12'd20, 4'd8);
    x = main_src; x.bus = ~main_src.bus;  add_frame(x, 4'd8, {PCI_SINGLE, 4'd3});
    x = main_src; x.id  = ~main_src.id;   add_frame(x, 4'd8, {PCI_SINGLE, 4'd3});
    x = main_src; x.ext = ~main_src.ext;  add_frame(x, 4'd8, {PCI_SINGLE, 4'd3});
    add_frame(main_src, 4'd3, 8'h30);                   // flow control, ignored
    add_frame(main_src, 4'd8, 8'hF5);                   // reserved type, ignored
    add_frame(main_src, 4'd8, {PCI_CONSECUTIVE, 4'd2}); // wrong sequence
    // Largest total; the second frame is one byte short after the sequence advanced.
    add_first(main_src, 12'd4095, 4'd8);
    add_frame(main_src, 4'd8, {PCI_CONSECUTIVE, 4'd1});
    add_frame(main_src, 4'd7, {PCI_CONSECUTIVE, 4'd2});
    // A new single frame from the same source abandons an open transfer.
    add_first(main_src, 12'd30, 4'd8);
    add_frame(main_src, 4'd4, {PCI_SINGLE, 4'd3});
    add_frame(b, 4'd8, {PCI_SINGLE, 4'd7});
    // All-ones and all-zero frames.
    f = '1;
    f.dlc = 4'd8;
    f.data_byte_0 = {PCI_SINGLE, 4'd7};
    frames_to_send.push_back(f);
    f = '0;
    f.dlc = 4'd8;
    f.data_byte_0 = {PCI_SINGLE, 4'd7};
    frames_to_send.push_back(f);
  endfunction

  // Mostly well-formed transfers and single frames with random content, the rest noise.
  function automatic void load_random(int frame_count);
    int pick;
    int len;
    // Close whatever the previous source left open before switching source.
    add_frame(main_src, 4'd8, {PCI_SINGLE, 4'd7});
    main_src = random_src();
    while (frames_to_send.size() < frame_count) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        add_transfer(main_src, ($urandom_range(0, 4) == 0) ? $urandom_range(61, 250)
                                                            : $urandom_range(8, 60), 1'b0);
      end else if (pick < 8) begin
        len = $urandom_range(1, 7);
        add_frame(main_src, 4'($urandom_range(len + 1, 8)), {PCI_SINGLE, 4'(len)});
      end else if (pick == 8) begin
        add_frame(main_src, 4'($urandom), 8'($urandom));
      end else begin
        add_foreign_noise(main_src);
      end
    end
  endfunction

  function automatic int unsigned pick_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer one frame word at a time, hold it while stalled, then idle a
  // random number of cycles before the next one.
  // ---------------------------------------------------------------------------
  int unsigned send_wait = 0;
  bit          send_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reassemble_frame(in_data);
        send_wait = pick_wait(send_burst);
        if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
      end
      if (in_valid && in_stall) begin
        // hold the stalled word
      end else if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (frames_to_send.size() > 0) begin
        in_data  <= frames_to_send.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each accepted output word with the oldest awaited word, and
  // stall a random number of cycles after each one.
  // ---------------------------------------------------------------------------
  int unsigned recv_hold = 0;
  int unsigned words_seen = 0;
  bit          recv_burst = 1'b0;
  bit          long_hold_done = 1'b0;

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (awaited_words.size() == 0) begin
      $error("output word with none awaited: %p", got);
      mismatches++;
      return;
    end
    want = awaited_words.pop_front();
    check_field("event_res", 32'(want.event_res), 32'(got.event_res));
    check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
    check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
    check_field("byte_offset", 32'(want.byte_offset), 32'(got.byte_offset));
    check_field("last_result", 32'(want.last_result), 32'(got.last_result));
    check_field("message_length", 32'(want.message_length), 32'(got.message_length));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        check_word(out_data);
        words_seen++;
        // Once, with plenty of frames still queued, stall long enough that the
        // job queue fills and the block stalls its input.
        if (!long_hold_done && words_seen >= 150 && frames_to_send.size() > 10) begin
          recv_hold      = 400;
          long_hold_done = 1'b1;
        end else begin
          recv_hold = pick_wait(recv_burst);
        end
        if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  // Wait until every frame is accepted and every awaited word has arrived, then
  // let the pipeline settle.
  task automatic settle(int cycles);
    while (frames_to_send.size() != 0 || in_valid || awaited_words.size() != 0)
      @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  // Write only while idle; the write also clears the block frame count.
  task automatic write_blk_limit(logic [7:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    blk_limit  = value;
    blk_frames = '0;
  endtask

  initial begin
    clear_transfer_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    main_src = random_src();
    load_directed();
    settle(8);
    load_random(35);
    settle(8);

    write_blk_limit(8'd1);
    load_random(35);
    settle(8);

    write_blk_limit(8'd3);
    load_random(35);
    settle(8);

    // Widest block: random transfers stay far below it, so only first frames request flow.
    write_blk_limit(8'd255);
    load_random(35);
    settle(8);

    write_blk_limit(8'($urandom_range(2, 254)));
    load_random(35);
    settle(8);

    write_blk_limit(8'd0);
    load_random(35);
    settle(20);

    if (mismatches == 0 && awaited_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
